FILE: hw/rtl/g6e_pkg.sv
// ============================================================================
// g6e_pkg
// Shared widths, character codes and helper functions of the graph6 encoder.
// ============================================================================
package g6e_pkg;

    localparam int VTX_W         = 7;
    localparam int CHAR_W        = 7;
    localparam int CHAR_BITS     = 6;
    localparam int DEF_MAX_ORDER = 64;
    localparam int VTX_LIMIT     = 127;
    localparam int SHORT_MAX     = 62;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int BIT_IDX_W     = 13;
    localparam int WORD_IDX_W    = 11;
    localparam int DIV6_MUL      = 2731;
    localparam int DIV6_SHIFT    = 13;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_GRAPH_ORDER = 1'b0;
    localparam logic REG_VERTEX_BASE = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_OFFSET  = 7'd63;
    localparam logic [CHAR_W-1:0] CHAR_LONG    = 7'd126;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;

    typedef struct packed {
        logic [WORD_IDX_W-1:0] q;
        logic [2:0]            r;
    } t_qr;

    function automatic int eff_limit(int max_order);
        return (max_order < VTX_LIMIT) ? max_order : VTX_LIMIT;
    endfunction

    function automatic int pair_count(int max_order);
        int m;
        m = eff_limit(max_order);
        return (m * (m - 1)) / 2;
    endfunction

    function automatic int store_depth(int max_order);
        return (pair_count(max_order) + 5) / 6;
    endfunction

    function automatic int width_of(int count);
        return (count > 1) ? $clog2(count) : 1;
    endfunction

    function automatic int cmd_width(int max_order);
        return 1 + width_of(store_depth(max_order)) + CHAR_BITS;
    endfunction

    // Division by six through a reciprocal multiply with one correction step.
    function automatic t_qr div6(logic [BIT_IDX_W-1:0] x);
        logic [2*(BIT_IDX_W-1)-1:0] prod;
        logic [WORD_IDX_W-1:0]      q0;
        logic [BIT_IDX_W-1:0]       rem;
        t_qr                        res;
        prod = (2*(BIT_IDX_W-1))'(x[BIT_IDX_W-1:1])
             * (2*(BIT_IDX_W-1))'(DIV6_MUL);
        q0   = prod[DIV6_SHIFT +: WORD_IDX_W];
        rem  = x - BIT_IDX_W'({q0, 2'b00}) - BIT_IDX_W'({q0, 1'b0});
        if (rem >= BIT_IDX_W'(6)) begin
            res.q = q0 + 1'b1;
            res.r = 3'(rem - BIT_IDX_W'(6));
        end else begin
            res.q = q0;
            res.r = 3'(rem);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/g6e_if.sv
// ============================================================================
// g6e_if
// Valid/ready channel interfaces for edge and read transactions and for
// output characters.
// ============================================================================
interface g6e_in_if;
    import g6e_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [VTX_W-1:0]  first_end;
    logic [VTX_W-1:0]  second_end;

    modport source (output valid, output kind, output first_end, output second_end,
                    input ready);
    modport sink   (input valid, input kind, input first_end, input second_end,
                    output ready);
endinterface

interface g6e_out_if;
    import g6e_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

FILE: hw/rtl/g6e_queue.sv
// ============================================================================
// g6e_queue
// Short command queue between the front end and the store back end.
// ============================================================================
module g6e_queue #(
    parameter int WIDTH = g6e_pkg::cmd_width(g6e_pkg::DEF_MAX_ORDER)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    import g6e_pkg::*;

    localparam int PTR_W = width_of(QUEUE_DEPTH);
    localparam int CNT_W = width_of(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] r_data [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_data[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: hw/rtl/g6e_front.sv
// ============================================================================
// g6e_front
// Accepts transactions, drops unusable edges and turns a kept edge into a
// store word index and bit mask.
// ============================================================================
module g6e_front #(
    parameter int MAX_ORDER = g6e_pkg::DEF_MAX_ORDER
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [g6e_pkg::VTX_W-1:0] i_order,
    input  logic                      i_base,
    g6e_in_if.sink                    i_in,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output logic [g6e_pkg::cmd_width(MAX_ORDER)-1:0] o_cmd
);
    import g6e_pkg::*;

    localparam int DEPTH  = store_depth(MAX_ORDER);
    localparam int ADDR_W = width_of(DEPTH);
    localparam int BIT_W  = width_of(pair_count(MAX_ORDER));
    localparam int TRI_W  = 2 * VTX_W;

    logic [VTX_W-1:0]  base_ext;
    logic [VTX_W-1:0]  a_rel;
    logic [VTX_W-1:0]  b_rel;
    logic [VTX_W-1:0]  u;
    logic [VTX_W-1:0]  v;
    logic [TRI_W-1:0]  tri_prod;
    logic [BIT_W-1:0]  bit_idx;
    logic              edge_ok;
    logic              keep_item;
    logic              s1_free;
    logic              accept;
    logic              r_s1_valid;
    logic              r_s1_read;
    logic [BIT_W-1:0]  r_s1_bit;
    t_qr               qr;

    assign base_ext = VTX_W'(i_base);
    assign a_rel    = i_in.first_end - base_ext;
    assign b_rel    = i_in.second_end - base_ext;
    assign edge_ok  = (i_in.first_end >= base_ext) && (i_in.second_end >= base_ext)
                   && (a_rel != b_rel) && (a_rel < i_order) && (b_rel < i_order);
    assign u        = (a_rel < b_rel) ? a_rel : b_rel;
    assign v        = (a_rel < b_rel) ? b_rel : a_rel;
    assign tri_prod = TRI_W'(v) * TRI_W'(v - 1'b1);
    assign bit_idx  = BIT_W'((tri_prod >> 1) + TRI_W'(u));

    assign keep_item  = (i_in.kind == KIND_READ) || edge_ok;
    assign s1_free    = !r_s1_valid || i_cmd_ready;
    assign accept     = i_in.valid && s1_free;
    assign i_in.ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept && keep_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_read <= (i_in.kind == KIND_READ);
            r_s1_bit  <= bit_idx;
        end
    end

    assign qr          = div6(BIT_IDX_W'(r_s1_bit));
    assign o_cmd_valid = r_s1_valid;
    assign o_cmd       = {r_s1_read, qr.q[ADDR_W-1:0],
                          CHAR_BITS'(6'b100000 >> qr.r)};

endmodule

FILE: hw/rtl/g6e_back.sv
// ============================================================================
// g6e_back
// Bit store with read-modify-write for edges, read-out sequencer for the
// graph6 line, store clearing pass and output register.
// ============================================================================
module g6e_back #(
    parameter int MAX_ORDER = g6e_pkg::DEF_MAX_ORDER
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [g6e_pkg::VTX_W-1:0] i_order,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  logic [g6e_pkg::cmd_width(MAX_ORDER)-1:0] i_cmd,
    g6e_out_if.source                 o_out
);
    import g6e_pkg::*;

    localparam int DEPTH   = store_depth(MAX_ORDER);
    localparam int ADDR_W  = width_of(DEPTH);
    localparam int DLEN_W  = width_of(DEPTH + 1);
    localparam int POS_W   = width_of(DEPTH + 5);
    localparam int K6_W    = POS_W + 3;
    localparam int NBITS_W = width_of(pair_count(MAX_ORDER) + 1);
    localparam int CMD_W   = cmd_width(MAX_ORDER);
    localparam int SQ_W    = 2 * VTX_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    typedef enum logic [1:0] {
        OP_EDGE,
        OP_HEAD,
        OP_DATA,
        OP_END
    } t_op;

    t_state               r_state;
    t_state               n_state;
    logic [ADDR_W-1:0]    r_clr_ptr;
    logic [ADDR_W-1:0]    n_clr_ptr;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [NBITS_W-1:0]   r_nbits;
    logic [DLEN_W-1:0]    r_dlen;
    logic [SQ_W-1:0]      order_sq;
    t_qr                  dlen_qr;

    logic [CHAR_BITS-1:0] r_mem [DEPTH];
    logic [CHAR_BITS-1:0] r_rdata;

    logic                 cmd_read;
    logic [ADDR_W-1:0]    cmd_word;
    logic [CHAR_BITS-1:0] cmd_mask;

    logic [2:0]           hlen;
    logic                 is_head;
    logic                 is_data;
    logic [POS_W-1:0]     k;
    logic [K6_W-1:0]      k6;
    logic [2:0]           keep;
    logic [CHAR_BITS-1:0] data_mask;
    logic [17:0]          n_ext;
    logic [CHAR_W-1:0]    head_char;

    t_op                  pop_op;
    logic [ADDR_W-1:0]    pop_addr;
    logic [CHAR_BITS-1:0] pop_mask;
    logic                 pop;

    logic                 r_e2_valid;
    t_op                  r_e2_op;
    logic [ADDR_W-1:0]    r_e2_addr;
    logic [CHAR_BITS-1:0] r_e2_mask;
    logic [CHAR_W-1:0]    r_e2_char;
    logic                 e2_free;
    logic                 e2_write;
    logic [CHAR_BITS-1:0] e2_old;
    logic [CHAR_BITS-1:0] e2_new;

    logic                 r_fwd_valid;
    logic [ADDR_W-1:0]    r_fwd_addr;
    logic [CHAR_BITS-1:0] r_fwd_data;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [CHAR_BITS-1:0] wr_data;

    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;
    logic                 out_free;

    // Line geometry follows the order register.
    assign order_sq = SQ_W'(i_order) * SQ_W'(i_order - 1'b1);
    assign dlen_qr  = div6(BIT_IDX_W'(r_nbits) + BIT_IDX_W'(5));

    always_ff @(posedge i_clk) begin
        r_nbits <= NBITS_W'(order_sq >> 1);
        r_dlen  <= DLEN_W'(dlen_qr.q);
    end

    assign cmd_read = i_cmd[CMD_W-1];
    assign cmd_word = i_cmd[CHAR_BITS +: ADDR_W];
    assign cmd_mask = i_cmd[CHAR_BITS-1:0];

    assign hlen    = (i_order > VTX_W'(SHORT_MAX)) ? 3'd4 : 3'd1;
    assign is_head = (r_pos < POS_W'(hlen));
    assign k       = r_pos - POS_W'(hlen);
    assign is_data = !is_head && (k < POS_W'(r_dlen));
    assign k6      = (K6_W'(k) << 2) + (K6_W'(k) << 1);
    assign keep    = 3'(K6_W'(r_nbits) - k6);
    assign n_ext   = 18'(i_order);

    always_comb begin
        if ((k6 + K6_W'(6)) > K6_W'(r_nbits)) begin
            data_mask = CHAR_BITS'(6'h3F << (3'd6 - keep));
        end else begin
            data_mask = 6'h3F;
        end
    end

    always_comb begin
        if (i_order <= VTX_W'(SHORT_MAX)) begin
            head_char = i_order + CHAR_OFFSET;
        end else begin
            case (r_pos[1:0])
                2'd0:    head_char = CHAR_LONG;
                2'd1:    head_char = CHAR_W'(n_ext[17:12]) + CHAR_OFFSET;
                2'd2:    head_char = CHAR_W'(n_ext[11:6]) + CHAR_OFFSET;
                default: head_char = CHAR_W'(n_ext[5:0]) + CHAR_OFFSET;
            endcase
        end
    end

    always_comb begin
        pop_addr = cmd_word;
        pop_mask = cmd_mask;
        if (!cmd_read) begin
            pop_op = OP_EDGE;
        end else if (is_head) begin
            pop_op = OP_HEAD;
        end else if (is_data) begin
            pop_op   = OP_DATA;
            pop_addr = k[ADDR_W-1:0];
            pop_mask = data_mask;
        end else begin
            pop_op = OP_END;
        end
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign e2_free     = !r_e2_valid || (r_e2_op == OP_EDGE) || out_free;
    assign o_cmd_ready = (r_state == ST_RUN) && e2_free;
    assign pop         = i_cmd_valid && o_cmd_ready;

    always_comb begin
        n_state   = r_state;
        n_clr_ptr = r_clr_ptr;
        n_pos     = r_pos;
        case (r_state)
            ST_CLEAR: begin
                n_clr_ptr = r_clr_ptr + 1'b1;
                if (r_clr_ptr == LAST_ADDR) begin
                    n_state   = ST_RUN;
                    n_clr_ptr = '0;
                end
            end
            ST_RUN: begin
                if (pop && cmd_read) begin
                    if (pop_op == OP_END) begin
                        n_pos   = '0;
                        n_state = ST_CLEAR;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_ptr <= '0;
            r_pos     <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_ptr <= n_clr_ptr;
            r_pos     <= n_pos;
        end
    end

    // A write at the edge that registered this stage's read is not yet visible
    // in the read data, so it is forwarded.
    assign e2_old   = (r_fwd_valid && (r_fwd_addr == r_e2_addr)) ? r_fwd_data : r_rdata;
    assign e2_new   = e2_old | r_e2_mask;
    assign e2_write = r_e2_valid && (r_e2_op == OP_EDGE);

    assign wr_en   = (r_state == ST_CLEAR) || e2_write;
    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_ptr : r_e2_addr;
    assign wr_data = (r_state == ST_CLEAR) ? '0 : e2_new;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (pop) begin
            r_rdata <= r_mem[pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (e2_free) begin
                r_e2_valid <= pop;
            end
            if (pop) begin
                r_fwd_valid <= e2_write;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e2_free) begin
            r_e2_op   <= pop_op;
            r_e2_addr <= pop_addr;
            r_e2_mask <= pop_mask;
            r_e2_char <= head_char;
        end
        if (pop) begin
            r_fwd_addr <= r_e2_addr;
            r_fwd_data <= e2_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_e2_valid && (r_e2_op != OP_EDGE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_e2_valid && out_free) begin
            case (r_e2_op)
                OP_HEAD: begin
                    r_out_char <= r_e2_char;
                    r_out_last <= 1'b0;
                end
                OP_DATA: begin
                    r_out_char <= CHAR_W'(e2_old & r_e2_mask) + CHAR_OFFSET;
                    r_out_last <= 1'b0;
                end
                OP_END: begin
                    r_out_char <= CHAR_NEWLINE;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_char <= r_out_char;
                    r_out_last <= r_out_last;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.last     = r_out_last;

endmodule

FILE: hw/rtl/graph6_adjacency_encoder_unit.sv
// ============================================================================
// graph6_adjacency_encoder_unit
// Encodes one simple graph as a graph6 text line, one character per read.
// ============================================================================
// Usage: write graph_order (address 0) and vertex_base (address 4) over the
// APB port while the block is idle. Then send transactions on i_in: kind 0
// adds the edge first_end/second_end, kind 1 requests the next character of
// the line, which comes out on o_out with last set on the closing newline.
// An edge or read transaction is accepted every cycle while i_in.ready is
// high; a read passes the front-end register, the queue, the store stage
// and the output register before its character appears, and an edge is
// visible to any later read. Edge and read transactions flow through a
// four-entry queue between the front end and the store, so each side stalls
// on its own. After reset and after every newline the store is cleared one
// word per cycle; transactions accepted in that time wait in the queue and
// i_in.ready drops once the queue and the front-end register are full. When
// o_out is stalled the pending character holds in the output register, the
// store pipeline stops and the queue fills, after which i_in.ready goes low.
// ============================================================================
module graph6_adjacency_encoder_unit #(
    parameter int MAX_ORDER = g6e_pkg::DEF_MAX_ORDER
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [g6e_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [g6e_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [g6e_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    g6e_in_if.sink                         i_in,
    g6e_out_if.source                      o_out
);
    import g6e_pkg::*;

    localparam int CMD_W = cmd_width(MAX_ORDER);

    logic [VTX_W-1:0] r_graph_order;
    logic             r_vertex_base;
    logic [VTX_W-1:0] order_eff;
    logic             cfg_write;
    logic             cmd_valid_f;
    logic             cmd_ready_f;
    logic [CMD_W-1:0] cmd_f;
    logic             cmd_valid_b;
    logic             cmd_ready_b;
    logic [CMD_W-1:0] cmd_b;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_graph_order <= VTX_W'(1);
            r_vertex_base <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_GRAPH_ORDER: r_graph_order <= pwdata[VTX_W-1:0];
                REG_VERTEX_BASE: r_vertex_base <= pwdata[0];
                default:         r_vertex_base <= r_vertex_base;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRAPH_ORDER: prdata = CFG_DATA_W'(r_graph_order);
            REG_VERTEX_BASE: prdata = CFG_DATA_W'(r_vertex_base);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        if (r_graph_order == '0) begin
            order_eff = VTX_W'(1);
        end else if (int'(r_graph_order) > MAX_ORDER) begin
            order_eff = VTX_W'(MAX_ORDER);
        end else begin
            order_eff = r_graph_order;
        end
    end

    g6e_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_order     (order_eff),
        .i_base      (r_vertex_base),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid_f),
        .i_cmd_ready (cmd_ready_f),
        .o_cmd       (cmd_f)
    );

    g6e_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_valid_f),
        .o_push_ready (cmd_ready_f),
        .i_push_data  (cmd_f),
        .o_pop_valid  (cmd_valid_b),
        .i_pop_ready  (cmd_ready_b),
        .o_pop_data   (cmd_b)
    );

    g6e_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_order     (order_eff),
        .i_cmd_valid (cmd_valid_b),
        .o_cmd_ready (cmd_ready_b),
        .i_cmd       (cmd_b),
        .o_out       (o_out)
    );

endmodule
